FILE: src/pi_duty_controller_with_capture_macros.svh
// assertion macros for the pi duty controller
`ifndef PI_DUTY_CONTROLLER_WITH_CAPTURE_MACROS_SVH
`define PI_DUTY_CONTROLLER_WITH_CAPTURE_MACROS_SVH

// generic clocked check, disabled during reset
`define PIDC_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// same-cycle implication
`define PIDC_IMPLIES(lbl, ante, cons, msg) \
   `PIDC_CHECK(lbl, ((ante) |-> (cons)), msg)

`endif

FILE: src/pidc_pkg.sv
// shared types and constants for the pi duty controller
`default_nettype none

package pidc_pkg;

   localparam int WAVE_LEN       = 1000;
   localparam int HALF_WAVE      = WAVE_LEN / 2;
   localparam int WAVE_W         = $clog2(WAVE_LEN);
   localparam int CAPTURE_POINTS = 200;

   localparam int ADC_W   = 10;
   localparam int ERR_W   = ADC_W + 1;
   localparam int GAIN_W  = 32;
   localparam int PER_W   = 16;
   localparam int CNT_W   = 8;
   localparam int IDX_W   = 3;

   // q16.16 duty arithmetic
   localparam int Q_FRAC   = 16;
   localparam int PPROD_W  = ERR_W + GAIN_W;
   localparam int IPROD_W  = 2 * GAIN_W;
   localparam int LIM_W    = 23;
   localparam int SCALED_W = LIM_W + PER_W;
   localparam int QUOT_W   = SCALED_W - Q_FRAC;
   localparam logic signed [IPROD_W-1:0] HALF_DUTY_Q16 = IPROD_W'(50 * 65536);
   localparam logic signed [IPROD_W-1:0] FULL_DUTY_Q16 = IPROD_W'(100 * 65536);
   localparam logic [LIM_W-1:0]          FULL_DUTY_LIM = LIM_W'(100 * 65536);

   // floor(q / 100) = (q * RECIP_100) >> RECIP_SHIFT, exact for q below 2**QUOT_W
   localparam int RECIP_SHIFT = QUOT_W + 7;
   localparam int RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
   localparam int QM_W        = QUOT_W + RECIP_W;

   localparam int PIPE_STAGES = 6;

   typedef enum logic [IDX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_PWM_PERIOD = 3'd2,
      CSR_REF_HIGH   = 3'd3,
      CSR_REF_LOW    = 3'd4,
      CSR_DECIMATION = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [ADC_W-1:0] adc_sample;
      logic             arm_capture;
   } req_payload_type;

   typedef struct packed {
      logic [PER_W-1:0] duty_compare;
      logic             capture_valid;
      logic [CNT_W-1:0] capture_index;
      logic [ADC_W-1:0] capture_adc;
      logic [ADC_W-1:0] capture_ref;
      logic             capture_last;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic        [PER_W-1:0]  pwm_period;
      logic        [ADC_W-1:0]  ref_high;
      logic        [ADC_W-1:0]  ref_low;
      logic        [CNT_W-1:0]  decimation;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] index;
      logic [ADC_W-1:0] adc;
      logic [ADC_W-1:0] ref_level;
      logic             last;
   } capture_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [GAIN_W-1:0] error_sum;
      capture_type              capture;
   } front_out_type;

endpackage

`default_nettype wire

FILE: src/pidc_csr.sv
// configuration register file
`default_nettype none

module pidc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [pidc_pkg::IDX_W-1:0]      csr_index,
   input  wire logic [pidc_pkg::GAIN_W-1:0]     csr_wdata,
   output      pidc_pkg::cfg_type               cfg
);

   pidc_pkg::cfg_type cfg_ff;
   pidc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (pidc_pkg::csr_index_type'(csr_index))
            pidc_pkg::CSR_PROP_GAIN:  cfg_in.prop_gain  = csr_wdata;
            pidc_pkg::CSR_INTEG_GAIN: cfg_in.integ_gain = csr_wdata;
            pidc_pkg::CSR_PWM_PERIOD: cfg_in.pwm_period = csr_wdata[pidc_pkg::PER_W-1:0];
            pidc_pkg::CSR_REF_HIGH:   cfg_in.ref_high   = csr_wdata[pidc_pkg::ADC_W-1:0];
            pidc_pkg::CSR_REF_LOW:    cfg_in.ref_low    = csr_wdata[pidc_pkg::ADC_W-1:0];
            pidc_pkg::CSR_DECIMATION: cfg_in.decimation = csr_wdata[pidc_pkg::CNT_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain  <= '0;
         cfg_ff.integ_gain <= '0;
         cfg_ff.pwm_period <= pidc_pkg::PER_W'(3999);
         cfg_ff.ref_high   <= pidc_pkg::ADC_W'(800);
         cfg_ff.ref_low    <= pidc_pkg::ADC_W'(200);
         cfg_ff.decimation <= pidc_pkg::CNT_W'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/pidc_front.sv
// reference wave, saturating integrator and capture sequencing per transaction
`default_nettype none

module pidc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire pidc_pkg::req_payload_type req,
   input  wire pidc_pkg::cfg_type         cfg,
   output      pidc_pkg::front_out_type   result
);

   logic [pidc_pkg::WAVE_W-1:0]        wave_ff, wave_in;
   logic signed [pidc_pkg::GAIN_W-1:0] esum_ff, esum_in;
   logic                               capturing_ff, capturing_in;
   logic [pidc_pkg::CNT_W-1:0]         decim_ff, decim_in;
   logic [pidc_pkg::CNT_W-1:0]         point_ff, point_in;

   logic [pidc_pkg::ADC_W-1:0]         ref_level;
   logic signed [pidc_pkg::ERR_W-1:0]  err;
   logic signed [pidc_pkg::GAIN_W-1:0] esum_base;
   logic signed [pidc_pkg::GAIN_W:0]   esum_wide;
   logic                               active;
   logic [pidc_pkg::CNT_W-1:0]         decim_inc;
   logic [pidc_pkg::CNT_W-1:0]         point_base;
   logic [pidc_pkg::CNT_W-1:0]         point_inc;
   logic                               hit;
   logic                               last;

   always_comb begin
      ref_level = (wave_ff < pidc_pkg::WAVE_W'(pidc_pkg::HALF_WAVE)) ? cfg.ref_high : cfg.ref_low;
      err       = $signed({1'b0, ref_level}) - $signed({1'b0, req.adc_sample});

      // arming clears the integrator before this tick's accumulation
      esum_base = req.arm_capture ? '0 : esum_ff;
      esum_wide = (pidc_pkg::GAIN_W+1)'(esum_base) + (pidc_pkg::GAIN_W+1)'(err);
      if (esum_wide[pidc_pkg::GAIN_W] != esum_wide[pidc_pkg::GAIN_W-1]) begin
         esum_in = esum_wide[pidc_pkg::GAIN_W] ? {1'b1, {(pidc_pkg::GAIN_W-1){1'b0}}}
                                               : {1'b0, {(pidc_pkg::GAIN_W-1){1'b1}}};
      end else begin
         esum_in = esum_wide[pidc_pkg::GAIN_W-1:0];
      end

      active     = req.arm_capture | capturing_ff;
      decim_inc  = (req.arm_capture ? '0 : decim_ff) + 1'b1;
      point_base = req.arm_capture ? '0 : point_ff;
      point_inc  = point_base + 1'b1;
      hit        = active && (decim_inc == cfg.decimation);
      last       = hit && (point_inc == pidc_pkg::CNT_W'(pidc_pkg::CAPTURE_POINTS));

      decim_in     = active ? (hit ? '0 : decim_inc) : decim_ff;
      point_in     = hit ? (last ? '0 : point_inc) : point_base;
      capturing_in = active & ~last;

      wave_in = (wave_ff == pidc_pkg::WAVE_W'(pidc_pkg::WAVE_LEN - 1)) ? '0 : wave_ff + 1'b1;

      result.err               = err;
      result.error_sum         = esum_in;
      result.capture.valid     = hit;
      result.capture.index     = hit ? point_base : '0;
      result.capture.adc       = hit ? req.adc_sample : '0;
      result.capture.ref_level = hit ? ref_level : '0;
      result.capture.last      = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff      <= '0;
         esum_ff      <= '0;
         capturing_ff <= 1'b0;
         decim_ff     <= '0;
         point_ff     <= '0;
      end else if (accept) begin
         wave_ff      <= wave_in;
         esum_ff      <= esum_in;
         capturing_ff <= capturing_in;
         decim_ff     <= decim_in;
         point_ff     <= point_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/pidc_pipe.sv
// gain products, clamp and duty scaling pipeline with output register
`default_nettype none

module pidc_pipe (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output      logic                    in_ready,
   input  wire pidc_pkg::front_out_type in_data,
   input  wire pidc_pkg::cfg_type       cfg,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      pidc_pkg::rsp_payload_type rsp_data
);

   localparam int NS = pidc_pkg::PIPE_STAGES;

   logic [NS-1:0] valid_ff, valid_in, ready;

   // stage 1: error terms
   pidc_pkg::front_out_type                 s1_ff;
   // stage 2: gain products
   logic signed [pidc_pkg::PPROD_W-1:0]     s2_pprod_ff, s2_pprod_in;
   logic signed [pidc_pkg::IPROD_W-1:0]     s2_iprod_ff, s2_iprod_in;
   pidc_pkg::capture_type                   s2_cap_ff;
   // stage 3: clamped duty
   logic signed [pidc_pkg::IPROD_W-1:0]     s3_sum;
   logic [pidc_pkg::LIM_W-1:0]              s3_lim_ff, s3_lim_in;
   pidc_pkg::capture_type                   s3_cap_ff;
   // stage 4: duty times period
   logic [pidc_pkg::SCALED_W-1:0]           s4_scaled_ff, s4_scaled_in;
   pidc_pkg::capture_type                   s4_cap_ff;
   // stage 5: reciprocal multiply for the divide by 100
   logic [pidc_pkg::QM_W-1:0]               s5_qm_ff, s5_qm_in;
   pidc_pkg::capture_type                   s5_cap_ff;
   // output register
   pidc_pkg::rsp_payload_type               rsp_ff, rsp_in;

   always_comb begin
      ready[NS-1] = ~valid_ff[NS-1] | ~rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         ready[k] = ~valid_ff[k] | ready[k+1];
      end
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign in_ready  = ready[0];
   assign rsp_valid = valid_ff[NS-1];
   assign rsp_data  = rsp_ff;

   always_comb begin
      s2_pprod_in = pidc_pkg::PPROD_W'(s1_ff.err) * pidc_pkg::PPROD_W'(cfg.prop_gain);
      s2_iprod_in = pidc_pkg::IPROD_W'(s1_ff.error_sum) * pidc_pkg::IPROD_W'(cfg.integ_gain);

      s3_sum = pidc_pkg::IPROD_W'(s2_pprod_ff) + s2_iprod_ff + pidc_pkg::HALF_DUTY_Q16;
      if (s3_sum < 0) begin
         s3_lim_in = '0;
      end else if (s3_sum > pidc_pkg::FULL_DUTY_Q16) begin
         s3_lim_in = pidc_pkg::FULL_DUTY_LIM;
      end else begin
         s3_lim_in = s3_sum[pidc_pkg::LIM_W-1:0];
      end

      s4_scaled_in = pidc_pkg::SCALED_W'(s3_lim_ff) * pidc_pkg::SCALED_W'(cfg.pwm_period);

      s5_qm_in = pidc_pkg::QM_W'(s4_scaled_ff[pidc_pkg::SCALED_W-1:pidc_pkg::Q_FRAC])
                 * pidc_pkg::QM_W'(pidc_pkg::RECIP_100);

      rsp_in.duty_compare  = s5_qm_ff[pidc_pkg::RECIP_SHIFT +: pidc_pkg::PER_W];
      rsp_in.capture_valid = s5_cap_ff.valid;
      rsp_in.capture_index = s5_cap_ff.index;
      rsp_in.capture_adc   = s5_cap_ff.adc;
      rsp_in.capture_ref   = s5_cap_ff.ref_level;
      rsp_in.capture_last  = s5_cap_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_ff <= in_data;
      end
      if (ready[1]) begin
         s2_pprod_ff <= s2_pprod_in;
         s2_iprod_ff <= s2_iprod_in;
         s2_cap_ff   <= s1_ff.capture;
      end
      if (ready[2]) begin
         s3_lim_ff <= s3_lim_in;
         s3_cap_ff <= s2_cap_ff;
      end
      if (ready[3]) begin
         s4_scaled_ff <= s4_scaled_in;
         s4_cap_ff    <= s3_cap_ff;
      end
      if (ready[4]) begin
         s5_qm_ff  <= s5_qm_in;
         s5_cap_ff <= s4_cap_ff;
      end
      if (ready[5]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/pi_duty_controller_with_capture.sv
// top level of the pi duty controller with decimated capture
`default_nettype none

// One transaction per control tick, one result per transaction, a new
// transaction accepted every cycle unless req_stall is raised. The
// reference wave position, the saturating integrator and the capture
// counters advance in the cycle the transaction is accepted; the gain
// multiplies, clamp and duty scaling then run through a six-register
// pipeline. A stalled result holds in the output register while empty
// pipeline slots keep taking new transactions. Configuration writes are
// accepted every cycle and should be made while no transaction is in
// flight.

`include "pi_duty_controller_with_capture_macros.svh"

module pi_duty_controller_with_capture (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire pidc_pkg::req_payload_type   req_data,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      pidc_pkg::rsp_payload_type   rsp_data,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [pidc_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [pidc_pkg::GAIN_W-1:0] csr_wdata
);

   pidc_pkg::cfg_type       cfg;
   pidc_pkg::front_out_type front_data;
   logic                    pipe_ready;
   logic                    accept;
   logic                    capture_idle;
   logic                    capture_clear;
   logic                    capture_seen;
   logic                    index_in_range;

   assign req_stall = ~pipe_ready;
   assign accept    = req_valid & pipe_ready;

   pidc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .result (front_data)
   );

   pidc_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (pipe_ready),
      .in_data   (front_data),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign capture_idle   = rsp_valid & ~rsp_data.capture_valid;
   assign capture_clear  = (rsp_data.capture_index == '0) && (rsp_data.capture_adc == '0)
                           && (rsp_data.capture_ref == '0) && !rsp_data.capture_last;
   assign capture_seen   = rsp_valid & rsp_data.capture_valid;
   assign index_in_range = rsp_data.capture_index
                           < pidc_pkg::CNT_W'(pidc_pkg::CAPTURE_POINTS);

   `PIDC_IMPLIES(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall, "early stall")
   `PIDC_IMPLIES(a_idle_capture_zero, capture_idle, capture_clear, "stale capture")
   `PIDC_IMPLIES(a_capture_index_range, capture_seen, index_in_range, "index out of range")

endmodule

`default_nettype wire

FILE: sim/tb_pi_duty_controller_with_capture.sv
// self-checking testbench for the pi duty controller with decimated capture
`timescale 1ns / 1ps

module tb_pi_duty_controller_with_capture;

   localparam int  RAND_TICKS  = 830;
   localparam int  SETTLE      = pidc_pkg::PIPE_STAGES + 4;
   localparam int  CYCLE_LIMIT = 500000;
   localparam int  HOLD_AT     = 340;
   localparam int  HOLD_LEN    = 160;
   localparam int  PRINT_CAP   = 100;
   localparam logic [pidc_pkg::IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [pidc_pkg::IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam longint SUM_MAX  = 64'sd2147483647;
   localparam longint SUM_MIN  = -64'sd2147483648;
   localparam longint HALF_Q16 = 50 * 65536;
   localparam longint FULL_Q16 = 100 * 65536;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_valid  = 1'b0;
   logic                            req_stall;
   pidc_pkg::req_payload_type       req_data   = '0;
   logic                            rsp_valid;
   logic                            rsp_stall  = 1'b0;
   pidc_pkg::rsp_payload_type       rsp_data;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [pidc_pkg::IDX_W-1:0]      csr_index  = '0;
   logic [pidc_pkg::GAIN_W-1:0]     csr_wdata  = '0;

   pi_duty_controller_with_capture dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // controller mirror: configuration
   longint                     kp_q     = 0;
   longint                     ki_q     = 0;
   logic [pidc_pkg::PER_W-1:0] period_q = 16'd3999;
   logic [pidc_pkg::ADC_W-1:0] level_hi = 10'd800;
   logic [pidc_pkg::ADC_W-1:0] level_lo = 10'd200;
   logic [pidc_pkg::CNT_W-1:0] decim_q  = 8'd10;

   // controller mirror: state
   int                         wave_pos   = 0;
   longint                     integ_sum  = 0;
   bit                         capture_on = 1'b0;
   logic [pidc_pkg::CNT_W-1:0] decim_cnt  = '0;
   logic [pidc_pkg::CNT_W-1:0] point_cnt  = '0;

   pidc_pkg::req_payload_type  tick_queue[$];
   pidc_pkg::rsp_payload_type  predicted_outputs[$];
   int                         error_count = 0;
   int                         ticks_sent  = 0;
   int                         cycle_count = 0;

   function automatic void apply_csr(input logic [pidc_pkg::IDX_W-1:0] idx,
                                     input logic [31:0] data);
      case (idx)
         pidc_pkg::CSR_PROP_GAIN:  kp_q     = longint'($signed(data));
         pidc_pkg::CSR_INTEG_GAIN: ki_q     = longint'($signed(data));
         pidc_pkg::CSR_PWM_PERIOD: period_q = data[pidc_pkg::PER_W-1:0];
         pidc_pkg::CSR_REF_HIGH:   level_hi = data[pidc_pkg::ADC_W-1:0];
         pidc_pkg::CSR_REF_LOW:    level_lo = data[pidc_pkg::ADC_W-1:0];
         pidc_pkg::CSR_DECIMATION: decim_q  = data[pidc_pkg::CNT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic pidc_pkg::rsp_payload_type predict_tick(
      input pidc_pkg::req_payload_type t);
      logic [pidc_pkg::ADC_W-1:0] level;
      longint                     err;
      longint                     u;
      longint                     lim;
      longint                     duty;
      pidc_pkg::rsp_payload_type  r;
      level = (wave_pos < pidc_pkg::HALF_WAVE) ? level_hi : level_lo;
      err   = longint'(level) - longint'(t.adc_sample);
      if (t.arm_capture) begin
         integ_sum  = 0;
         capture_on = 1'b1;
         decim_cnt  = '0;
         point_cnt  = '0;
      end
      integ_sum = integ_sum + err;
      if (integ_sum > SUM_MAX) integ_sum = SUM_MAX;
      if (integ_sum < SUM_MIN) integ_sum = SUM_MIN;
      u   = err * kp_q + integ_sum * ki_q;
      lim = u + HALF_Q16;
      if (lim > FULL_Q16) lim = FULL_Q16;
      if (lim < 0) lim = 0;
      duty = (lim * longint'(period_q)) / FULL_Q16;
      r = '0;
      r.duty_compare = duty[pidc_pkg::PER_W-1:0];
      if (capture_on) begin
         decim_cnt = decim_cnt + 1'b1;
         if (decim_cnt == decim_q) begin
            decim_cnt       = '0;
            r.capture_valid = 1'b1;
            r.capture_index = point_cnt;
            r.capture_adc   = t.adc_sample;
            r.capture_ref   = level;
            point_cnt       = point_cnt + 1'b1;
            if (point_cnt == pidc_pkg::CNT_W'(pidc_pkg::CAPTURE_POINTS)) begin
               r.capture_last = 1'b1;
               point_cnt      = '0;
               capture_on     = 1'b0;
            end
         end
      end
      wave_pos = (wave_pos + 1 >= pidc_pkg::WAVE_LEN) ? 0 : wave_pos + 1;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint want, input longint got);
      if (error_count < PRINT_CAP)
         $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
      error_count++;
   endtask

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_outputs.push_back(predict_tick(req_data));
            ticks_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
               req_data  <= tick_queue.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   int  stall_mode  = 0;
   int  mode_left   = 0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;
   int  stall_phase = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && ticks_sent >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 96);
         end
         mode_left--;
         stall_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 6);
               default: rsp_stall <= (stall_phase % 4 == 0);
            endcase
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      pidc_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_outputs.size() == 0) begin
            report_mismatch("unexpected transaction", 0, rsp_data.duty_compare);
         end else begin
            want = predicted_outputs.pop_front();
            if (rsp_data.duty_compare !== want.duty_compare)
               report_mismatch("duty_compare", want.duty_compare, rsp_data.duty_compare);
            if (rsp_data.capture_valid !== want.capture_valid)
               report_mismatch("capture_valid", want.capture_valid, rsp_data.capture_valid);
            if (rsp_data.capture_index !== want.capture_index)
               report_mismatch("capture_index", want.capture_index, rsp_data.capture_index);
            if (rsp_data.capture_adc !== want.capture_adc)
               report_mismatch("capture_adc", want.capture_adc, rsp_data.capture_adc);
            if (rsp_data.capture_ref !== want.capture_ref)
               report_mismatch("capture_ref", want.capture_ref, rsp_data.capture_ref);
            if (rsp_data.capture_last !== want.capture_last)
               report_mismatch("capture_last", want.capture_last, rsp_data.capture_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic push_tick(input int adc, input bit arm);
      pidc_pkg::req_payload_type t;
      t.adc_sample  = pidc_pkg::ADC_W'(adc);
      t.arm_capture = arm;
      tick_queue.push_back(t);
   endtask

   task automatic wait_idle();
      while (tick_queue.size() != 0 || req_valid || predicted_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [pidc_pkg::IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic write_settings(input logic [31:0] kp, input logic [31:0] ki,
                                 input logic [pidc_pkg::PER_W-1:0] per,
                                 input logic [pidc_pkg::ADC_W-1:0] hi,
                                 input logic [pidc_pkg::ADC_W-1:0] lo,
                                 input logic [pidc_pkg::CNT_W-1:0] dec);
      logic [31:0] pad;
      pad = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom();
      csr_write(pidc_pkg::CSR_PROP_GAIN, kp);
      csr_write(pidc_pkg::CSR_INTEG_GAIN, ki);
      csr_write(pidc_pkg::CSR_PWM_PERIOD, {pad[31:pidc_pkg::PER_W], per});
      csr_write(pidc_pkg::CSR_REF_HIGH, {pad[31:pidc_pkg::ADC_W], hi});
      csr_write(pidc_pkg::CSR_REF_LOW, {pad[31:pidc_pkg::ADC_W], lo});
      csr_write(pidc_pkg::CSR_DECIMATION, {pad[31:pidc_pkg::CNT_W], dec});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_gain(input int span_log2);
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         5: return $urandom();
         default: return $urandom_range(0, 1 << (span_log2 + 1)) - (1 << span_log2);
      endcase
   endfunction

   task automatic random_settings(input bit first);
      logic [31:0]                kp;
      logic [31:0]                ki;
      logic [pidc_pkg::PER_W-1:0] per;
      logic [pidc_pkg::ADC_W-1:0] hi;
      logic [pidc_pkg::ADC_W-1:0] lo;
      logic [pidc_pkg::CNT_W-1:0] dec;
      kp = pick_gain(18);
      ki = pick_gain(12);
      case ($urandom_range(0, 3))
         0: per = '0;
         1: per = '1;
         default: per = pidc_pkg::PER_W'($urandom());
      endcase
      case ($urandom_range(0, 3))
         0: hi = '0;
         1: hi = '1;
         default: hi = pidc_pkg::ADC_W'($urandom());
      endcase
      case ($urandom_range(0, 3))
         0: lo = '0;
         1: lo = '1;
         default: lo = pidc_pkg::ADC_W'($urandom());
      endcase
      case ($urandom_range(0, 7))
         0, 1, 2: dec = 8'd1;
         3: dec = 8'd2;
         4: dec = 8'd0;
         5: dec = 8'd255;
         default: dec = pidc_pkg::CNT_W'($urandom_range(1, 20));
      endcase
      if (first) dec = 8'd1;
      write_settings(kp, ki, per, hi, lo, dec);
   endtask

   initial begin
      int  made;
      int  len;
      bit  noisy;
      bit  start_armed;
      bit  arm;
      int  adc;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset configuration
      push_tick(800, 1'b0);
      push_tick(0, 1'b1);
      push_tick(1023, 1'b0);
      wait_idle();

      // spare register indexes must not disturb anything
      csr_write(CSR_SPARE_LO, $urandom());
      csr_write(CSR_SPARE_HI, $urandom());
      write_settings(32'h0001_0000, 32'h0000_0100, 16'hFFFF, 10'd1023, 10'd0, 8'd1);
      push_tick(0, 1'b1);
      push_tick(1023, 1'b0);
      push_tick(0, 1'b0);
      push_tick(512, 1'b0);
      push_tick(1023, 1'b1);
      push_tick(1023, 1'b0);
      push_tick(1, 1'b0);
      push_tick(1022, 1'b0);
      wait_idle();

      // gain extremes, zero period
      write_settings(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 10'd0, 10'd1023, 8'd255);
      push_tick(1023, 1'b1);
      push_tick(0, 1'b0);
      push_tick(1023, 1'b0);
      push_tick(0, 1'b1);
      wait_idle();

      // opposite gain extremes, zero decimation
      write_settings(32'h7FFF_FFFF, 32'h8000_0000, 16'd100, 10'd512, 10'd512, 8'd0);
      push_tick(0, 1'b1);
      push_tick(1023, 1'b0);
      push_tick(512, 1'b0);
      push_tick(511, 1'b0);
      push_tick(513, 1'b0);
      wait_idle();

      made = 0;
      while (made < RAND_TICKS) begin
         random_settings(made == 0);
         len         = (made == 0) ? 260 : $urandom_range(120, 260);
         if (len > RAND_TICKS - made) len = RAND_TICKS - made;
         noisy       = ($urandom_range(0, 3) == 0);
         start_armed = ($urandom_range(0, 9) != 0);
         for (int i = 0; i < len; i++) begin
            if (i == 0)
               arm = start_armed;
            else if (noisy)
               arm = ($urandom_range(0, 9) == 0);
            else
               arm = ($urandom_range(0, 399) == 0);
            case ($urandom_range(0, 9))
               0: adc = 0;
               1: adc = 1023;
               default: adc = $urandom_range(0, 1023);
            endcase
            push_tick(adc, arm);
         end
         made += len;
         wait_idle();
      end

      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
